// ===== src/bb3_pkg.sv =====
// Shared types and constants for the 3x3 box blur.
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WCFG_W     = 11;
    localparam int HCFG_W     = 13;
    localparam int CFG_W      = 13;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int NUM_W      = SUM_W + 1;
    localparam int DEN_W      = CNT_W + 1;
    localparam int QDEPTH     = 2;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_DRAIN = 1'b1
    } t_func;

    typedef logic [23:0] t_pix;

    typedef struct packed {
        logic       func;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_in_run;
        logic       last_of_frame;
    } t_out;

    typedef struct packed {
        logic             is_drain;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] lo;
        logic [COL_W-1:0] hi;
        logic             r_ge1;
        logic             r_ge2;
        logic             c_last;
        logic             use_old;
        logic             last;
        t_pix             pix;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PWIN,
        S_PSUM,
        S_DACC,
        S_LOAD,
        S_DIV,
        S_OUT
    } t_bstate;

endpackage

// ===== src/box_blur_3x3_edge_clipped_top.sv =====
// Top level of the 3x3 edge-clipped box blur.
//
// Input channel (i_valid/o_ready, i_data): func 0 carries one RGB pixel in raster
// order, func 1 drains one output pixel of the final row after the last pixel.
// Pixels sent while draining and drains sent otherwise are taken and dropped.
// Output channel (o_valid/i_ready, o_data): per-channel rounded mean of the
// in-frame 3x3 neighborhood, lagging one row and one column behind the input.
// Configuration: i_cfg_we writes image_width (index 0) or image_height (index 1)
// and restarts the frame; write only while no request is in flight.
// Flow: the back end handles one request at a time. A pixel updates the window
// and line stores, then for each result it gives (0, 1 or 2) runs the sum, load,
// 8-step divide and output. A drain sums the line store reads for its columns,
// then loads, divides and outputs, paced by the serial divider and single read port.
// A two-entry queue lets the front end keep accepting while the back end works.
// Reset clears the frame position, queue and output valid; line stores are
// not cleared. When the receiver stalls, the result holds in the output register
// and requests back up into the queue until o_ready drops.
module box_blur_3x3_edge_clipped_top
    import bb3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in              i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out             o_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_cmd f_cmd;
    t_cmd q_cmd;

    bb3_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (f_cmd)
    );

    bb3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (q_cmd)
    );

    bb3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// ===== src/bb3_front.sv =====
// Front end: accepts requests, tracks frame position, issues work commands.
module bb3_front
    import bb3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in              i_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [COL_W-1:0] r_wlast, n_wlast;
    logic [ROW_W-1:0] r_hlast, n_hlast;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_drain, n_drain;
    logic             r_draining, n_draining;
    logic             accept;
    logic [WCFG_W-1:0] wcfg;
    logic [HCFG_W-1:0] hcfg;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign wcfg    = i_cfg_data[WCFG_W-1:0];
    assign hcfg    = i_cfg_data[HCFG_W-1:0];

    always_comb begin
        n_wlast    = r_wlast;
        n_hlast    = r_hlast;
        n_col      = r_col;
        n_row      = r_row;
        n_drain    = r_drain;
        n_draining = r_draining;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd.col  = r_col;
        o_cmd.pix  = {i_data.in_red, i_data.in_green, i_data.in_blue};
        o_cmd.r_ge1   = (r_row != '0);
        o_cmd.r_ge2   = (r_row >= ROW_W'(2));
        o_cmd.c_last  = (r_col == r_wlast);
        o_cmd.is_drain = (i_data.func == FUNC_DRAIN);
        o_cmd.lo      = (r_drain != '0) ? r_drain - COL_W'(1) : r_drain;
        o_cmd.hi      = (r_drain != r_wlast) ? r_drain + COL_W'(1) : r_drain;
        o_cmd.use_old = (r_hlast != '0);
        o_cmd.last    = (r_drain == r_wlast);
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH: begin
                    if (wcfg == '0) begin
                        n_wlast = '0;
                    end else if (wcfg > WCFG_W'(MAX_WIDTH)) begin
                        n_wlast = COL_W'(MAX_WIDTH - 1);
                    end else begin
                        n_wlast = COL_W'(wcfg - WCFG_W'(1));
                    end
                end
                REG_HEIGHT: begin
                    if (hcfg == '0) begin
                        n_hlast = '0;
                    end else if (hcfg > HCFG_W'(MAX_HEIGHT)) begin
                        n_hlast = ROW_W'(MAX_HEIGHT - 1);
                    end else begin
                        n_hlast = ROW_W'(hcfg - HCFG_W'(1));
                    end
                end
                default: begin
                end
            endcase
            n_col      = '0;
            n_row      = '0;
            n_drain    = '0;
            n_draining = 1'b0;
        end else if (accept) begin
            if (i_data.func == FUNC_PIXEL && !r_draining) begin
                o_push = 1'b1;
                if (r_col == r_wlast) begin
                    n_col = '0;
                    if (r_row == r_hlast) begin
                        n_draining = 1'b1;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end else if (i_data.func == FUNC_DRAIN && r_draining) begin
                o_push = 1'b1;
                if (r_drain == r_wlast) begin
                    n_col      = '0;
                    n_row      = '0;
                    n_drain    = '0;
                    n_draining = 1'b0;
                end else begin
                    n_drain = r_drain + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast    <= COL_W'(MAX_WIDTH - 1);
            r_hlast    <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_drain    <= '0;
            r_draining <= 1'b0;
        end else begin
            r_wlast    <= n_wlast;
            r_hlast    <= n_hlast;
            r_col      <= n_col;
            r_row      <= n_row;
            r_drain    <= n_drain;
            r_draining <= n_draining;
        end
    end

endmodule

// ===== src/bb3_queue.sv =====
// Two-entry command queue between front end and back end.
module bb3_queue
    import bb3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(QDEPTH);

    t_cmd             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (PTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (PTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== src/bb3_back.sv =====
// Back end: line stores, 3x3 window, neighborhood sums, serial divide, output register.
module bb3_back
    import bb3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_bstate          r_state, n_state;
    t_cmd             r_cmd;
    t_pix             mem_old [MAX_WIDTH];
    t_pix             mem_new [MAX_WIDTH];
    t_pix             r_rdo;
    t_pix             r_rdn;
    logic [COL_W-1:0] rd_addr;
    logic             we;
    t_pix             r_win [3][3];
    logic [SUM_W-1:0] r_sum [3];
    logic [CNT_W-1:0] r_n;
    logic [NUM_W-1:0] r_rem [3];
    logic [DEN_W-1:0] r_den;
    logic [7:0]       r_q [3];
    logic [2:0]       r_k;
    logic             r_second;
    logic             r_more;
    logic [COL_W-1:0] r_x;
    logic             r_ov;
    t_out             r_od;
    logic             out_load;
    logic [1:0]       fc;
    logic [SUM_W-1:0] sum_c [3];
    logic [CNT_W-1:0] n_c;
    logic [NUM_W-1:0] dsh;

    assign o_valid  = r_ov;
    assign o_data   = r_od;
    assign out_load = (r_state == S_OUT) && (!r_ov || i_ready);
    assign dsh      = NUM_W'(r_den) << r_k;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        rd_addr = r_x + COL_W'(1);
        we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    rd_addr = i_cmd.is_drain ? i_cmd.lo : i_cmd.col;
                    n_state = i_cmd.is_drain ? S_DACC : S_PWIN;
                end
            end
            S_PWIN: begin
                we = 1'b1;
                n_state = (r_cmd.r_ge1 && (r_cmd.col != '0 || r_cmd.c_last)) ?
                          S_PSUM : S_IDLE;
            end
            S_PSUM: n_state = S_LOAD;
            S_DACC: begin
                if (r_x == r_cmd.hi) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (r_k == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_state = r_more ? S_PSUM : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (!r_second) begin
            fc = (r_cmd.col >= COL_W'(2)) ? 2'd0 : 2'd1;
        end else begin
            fc = (r_cmd.col != '0) ? 2'd1 : 2'd2;
        end
        n_c = '0;
        for (int j = 0; j < 3; j++) begin
            sum_c[j] = '0;
        end
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (2'(c) >= fc && (r != 0 || r_cmd.r_ge2)) begin
                    n_c = n_c + CNT_W'(1);
                    for (int j = 0; j < 3; j++) begin
                        sum_c[j] = sum_c[j] + SUM_W'(r_win[c][r][23-8*j -: 8]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdo <= mem_old[rd_addr];
        r_rdn <= mem_new[rd_addr];
        if (we) begin
            mem_old[r_cmd.col] <= r_rdn;
            mem_new[r_cmd.col] <= r_cmd.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    r_cmd <= i_cmd;
                    r_x   <= i_cmd.lo;
                    r_n   <= '0;
                    for (int j = 0; j < 3; j++) begin
                        r_sum[j] <= '0;
                    end
                end
            end
            S_PWIN: begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2][0] <= r_rdo;
                r_win[2][1] <= r_rdn;
                r_win[2][2] <= r_cmd.pix;
                r_second <= (r_cmd.col == '0);
                r_more   <= r_cmd.r_ge1 && (r_cmd.col != '0) && r_cmd.c_last;
            end
            S_PSUM: begin
                r_sum <= sum_c;
                r_n   <= n_c;
            end
            S_DACC: begin
                for (int j = 0; j < 3; j++) begin
                    r_sum[j] <= r_sum[j] + SUM_W'(r_rdn[23-8*j -: 8]) +
                                (r_cmd.use_old ? SUM_W'(r_rdo[23-8*j -: 8]) : '0);
                end
                r_n <= r_n + (r_cmd.use_old ? CNT_W'(2) : CNT_W'(1));
                r_x <= r_x + COL_W'(1);
            end
            S_LOAD: begin
                for (int j = 0; j < 3; j++) begin
                    r_rem[j] <= {r_sum[j], 1'b0} + NUM_W'(r_n);
                    r_q[j]   <= '0;
                end
                r_den <= {r_n, 1'b0};
                r_k   <= 3'd7;
            end
            S_DIV: begin
                for (int j = 0; j < 3; j++) begin
                    if (r_rem[j] >= dsh) begin
                        r_rem[j]     <= r_rem[j] - dsh;
                        r_q[j][r_k]  <= 1'b1;
                    end
                end
                r_k <= r_k - 3'd1;
            end
            S_OUT: begin
                if (out_load) begin
                    r_od.out_red       <= r_q[0];
                    r_od.out_green     <= r_q[1];
                    r_od.out_blue      <= r_q[2];
                    r_od.last_in_run   <= r_cmd.is_drain || !r_more;
                    r_od.last_of_frame <= r_cmd.is_drain && r_cmd.last;
                    if (r_more) begin
                        r_second <= 1'b1;
                        r_more   <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

// ===== src/bb3_checker.sv =====
// Port-level checks for the box blur top level, bound to it.
module bb3_checker
    import bb3_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output request dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("output payload changed while stalled");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last_of_frame |-> o_data.last_in_run)
        else $error("frame end without end of run");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind box_blur_3x3_edge_clipped_top bb3_checker u_bb3_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
